// ----- design/cartesian_to_polar_range_rate_unit_assert.svh -----
// Assertion macros for the polar conversion unit
`ifndef CARTESIAN_TO_POLAR_RANGE_RATE_UNIT_ASSERT_SVH
`define CARTESIAN_TO_POLAR_RANGE_RATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define C2P_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("c2p assertion failed");
// Check a property on every clock edge, reset included
`define C2P_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("c2p assertion failed");
`else
`define C2P_ASSERT(lbl, clk, rstn, prop)
`define C2P_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- design/c2p_pkg.sv -----
// Constants and tables for the polar conversion unit
`default_nettype none
package c2p_pkg;
  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 20;
  localparam int ANG_BITS      = 30;
  localparam int SQRT_STAGES   = 32;
  localparam int DIV_STAGES    = 32;
  localparam int BRG_W         = 19;
  localparam int BRG_SH        = ANG_BITS - FRAC_BITS;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint BRG_LIM     = (PI_Q30 + (64'sd1 <<< (BRG_SH - 1))) >>> BRG_SH;

  // Arctangent of 2^-i in Q2.30
  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] r;
    case (idx)
      0: r = 32'd843314857;
      1: r = 32'd497837829;
      2: r = 32'd263043837;
      3: r = 32'd133525159;
      4: r = 32'd67021687;
      5: r = 32'd33543516;
      6: r = 32'd16775851;
      7: r = 32'd8388437;
      8: r = 32'd4194283;
      9: r = 32'd2097149;
      default: r = (idx < 30) ? (32'd1 << (30 - idx)) : 32'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- design/cartesian_to_polar_range_rate_unit.sv -----
// Cartesian state to range, bearing and range rate, fully pipelined
//
// One transaction enters per clock unless the pipeline holds, and passes through a
// products stage and a sums stage, a 32-stage square root (one root bit per stage, the
// bearing CORDIC running alongside it), a range clamp stage, a 32-stage
// restoring divider (one quotient bit per stage) and the output register.
// The square root and divider stage counts set the latency. The whole
// pipeline holds while the output register holds an untaken result.
`default_nettype none
`include "cartesian_to_polar_range_rate_unit_assert.svh"
module cartesian_to_polar_range_rate_unit
  import c2p_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic signed [31:0]      pos_x_i,
  input  wire logic signed [31:0]      pos_y_i,
  input  wire logic signed [31:0]      vel_x_i,
  input  wire logic signed [31:0]      vel_y_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [31:0]                  range_out_o,
  output logic signed [BRG_W-1:0]      bearing_out_o,
  output logic signed [31:0]           range_rate_out_o
);

  logic adv;
  logic out_v_q;

  // Advance everything unless the output holds an untaken result
  assign adv        = !(out_v_q && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 1: products
  logic               s1_v_q;
  logic signed [63:0] s1_xx_q, s1_yy_q, s1_p1_q, s1_p2_q;
  logic signed [31:0] s1_px_q, s1_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (adv) s1_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_xx_q <= pos_x_i * pos_x_i;
      s1_yy_q <= pos_y_i * pos_y_i;
      s1_p1_q <= pos_x_i * vel_x_i;
      s1_p2_q <= pos_y_i * vel_y_i;
      s1_px_q <= pos_x_i;
      s1_py_q <= pos_y_i;
    end
  end

  // Stage 2: sums, dot magnitude, CORDIC quadrant fold
  logic               s2_v_q;
  logic [63:0]        s2_sum_q, s2_mag_q;
  logic               s2_neg_q, s2_org_q;
  logic signed [65:0] s2_x_q, s2_y_q;
  logic signed [34:0] s2_z_q;
  logic signed [64:0] dot;
  logic signed [65:0] x0, y0;

  assign dot = 65'(s1_p1_q) + 65'(s1_p2_q);
  assign x0  = 66'(s1_px_q) <<< ANG_BITS;
  assign y0  = 66'(s1_py_q) <<< ANG_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (adv) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sum_q <= 64'(s1_xx_q) + 64'(s1_yy_q);
      s2_neg_q <= dot < 0;
      s2_mag_q <= (dot < 0) ? 64'(-dot) : 64'(dot);
      s2_org_q <= (s1_px_q == 0) && (s1_py_q == 0);
      if (x0 < 0) begin
        if (y0 >= 0) begin
          s2_x_q <= y0;
          s2_y_q <= -x0;
          s2_z_q <= 35'(HALF_PI_Q30);
        end else begin
          s2_x_q <= -y0;
          s2_y_q <= x0;
          s2_z_q <= -35'(HALF_PI_Q30);
        end
      end else begin
        s2_x_q <= x0;
        s2_y_q <= y0;
        s2_z_q <= '0;
      end
    end
  end

  // Square root stages with the CORDIC alongside
  logic               sq_v_q    [SQRT_STAGES];
  logic [63:0]        sq_rem_q  [SQRT_STAGES];
  logic [31:0]        sq_root_q [SQRT_STAGES];
  logic [63:0]        sq_mag_q  [SQRT_STAGES];
  logic               sq_neg_q  [SQRT_STAGES];
  logic               sq_org_q  [SQRT_STAGES];
  logic signed [65:0] cx_q      [SQRT_STAGES];
  logic signed [65:0] cy_q      [SQRT_STAGES];
  logic signed [34:0] cz_q      [SQRT_STAGES];
  logic signed [BRG_W-1:0] brg_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sq
    localparam int B = SQRT_STAGES - 1 - k;
    logic               v_in, neg_in, org_in;
    logic [63:0]        rem_in, mag_in;
    logic [31:0]        root_in;
    logic signed [65:0] x_in, y_in;
    logic signed [34:0] z_in;
    logic signed [BRG_W-1:0] brg_in;
    logic [65:0]        trial;
    logic signed [34:0] zr;

    if (k == 0) begin : g_first
      assign v_in    = s2_v_q;
      assign rem_in  = s2_sum_q;
      assign root_in = '0;
      assign mag_in  = s2_mag_q;
      assign neg_in  = s2_neg_q;
      assign org_in  = s2_org_q;
      assign x_in    = s2_x_q;
      assign y_in    = s2_y_q;
      assign z_in    = s2_z_q;
      assign brg_in  = '0;
    end else begin : g_next
      assign v_in    = sq_v_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign mag_in  = sq_mag_q[k-1];
      assign neg_in  = sq_neg_q[k-1];
      assign org_in  = sq_org_q[k-1];
      assign x_in    = cx_q[k-1];
      assign y_in    = cy_q[k-1];
      assign z_in    = cz_q[k-1];
      assign brg_in  = brg_q[k-1];
    end

    // Trial subtrahend for this root bit: (2r + 2^B) * 2^B
    assign trial = ({34'd0, root_in} << (B + 1)) + (66'd1 << (2 * B));
    // Round the angle to output precision
    assign zr = (z_in + 35'(64'sd1 <<< (BRG_SH - 1))) >>> BRG_SH;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k] <= 1'b0;
      else if (adv) sq_v_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_mag_q[k] <= mag_in;
        sq_neg_q[k] <= neg_in;
        sq_org_q[k] <= org_in;
        if ({2'b00, rem_in} >= trial) begin
          sq_rem_q[k]  <= rem_in - trial[63:0];
          sq_root_q[k] <= root_in | (32'd1 << B);
        end else begin
          sq_rem_q[k]  <= rem_in;
          sq_root_q[k] <= root_in;
        end
        if (k < CORDIC_STAGES) begin
          if (y_in >= 0) begin
            cx_q[k] <= x_in + (y_in >>> k);
            cy_q[k] <= y_in - (x_in >>> k);
            cz_q[k] <= z_in + $signed({3'b000, atan_q30(k)});
          end else begin
            cx_q[k] <= x_in - (y_in >>> k);
            cy_q[k] <= y_in + (x_in >>> k);
            cz_q[k] <= z_in - $signed({3'b000, atan_q30(k)});
          end
          brg_q[k] <= brg_in;
        end else begin
          cx_q[k] <= x_in;
          cy_q[k] <= y_in;
          cz_q[k] <= z_in;
          if (k == CORDIC_STAGES) begin
            if (org_in) brg_q[k] <= '0;
            else if (zr > 35'(BRG_LIM)) brg_q[k] <= BRG_W'(BRG_LIM);
            else if (zr < -35'(BRG_LIM)) brg_q[k] <= -BRG_W'(BRG_LIM);
            else brg_q[k] <= zr[BRG_W-1:0];
          end else begin
            brg_q[k] <= brg_in;
          end
        end
      end
    end
  end

  // Range clamp and divider setup
  logic        dp_v_q, dp_neg_q, dp_ovf_q;
  logic [31:0] dp_rho_q, dp_lo_q;
  logic [31:0] dp_rem_q;
  logic signed [BRG_W-1:0] dp_brg_q;
  logic [31:0] rho_c;
  logic [63:0] mag_l;

  assign rho_c = (sq_root_q[SQRT_STAGES-1] == 0) ? 32'd1 : sq_root_q[SQRT_STAGES-1];
  assign mag_l = sq_mag_q[SQRT_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dp_v_q <= 1'b0;
    else if (adv) dp_v_q <= sq_v_q[SQRT_STAGES-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dp_rho_q <= rho_c;
      dp_neg_q <= sq_neg_q[SQRT_STAGES-1];
      dp_ovf_q <= mag_l[63:32] >= rho_c;
      dp_rem_q <= (mag_l[63:32] >= rho_c) ? 32'd0 : mag_l[63:32];
      dp_lo_q  <= mag_l[31:0];
      dp_brg_q <= brg_q[SQRT_STAGES-1];
    end
  end

  // Restoring divider stages, one quotient bit each
  logic        dv_v_q   [DIV_STAGES];
  logic [31:0] dv_rem_q [DIV_STAGES];
  logic [31:0] dv_lo_q  [DIV_STAGES];
  logic [31:0] dv_q_q   [DIV_STAGES];
  logic [31:0] dv_rho_q [DIV_STAGES];
  logic        dv_neg_q [DIV_STAGES];
  logic        dv_ovf_q [DIV_STAGES];
  logic signed [BRG_W-1:0] dv_brg_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_dv
    localparam int B = DIV_STAGES - 1 - j;
    logic        v_in, neg_in, ovf_in;
    logic [31:0] rem_in, lo_in, q_in, rho_in;
    logic signed [BRG_W-1:0] brg_in;
    logic [32:0] r2;

    if (j == 0) begin : g_first
      assign v_in   = dp_v_q;
      assign rem_in = dp_rem_q;
      assign lo_in  = dp_lo_q;
      assign q_in   = '0;
      assign rho_in = dp_rho_q;
      assign neg_in = dp_neg_q;
      assign ovf_in = dp_ovf_q;
      assign brg_in = dp_brg_q;
    end else begin : g_next
      assign v_in   = dv_v_q[j-1];
      assign rem_in = dv_rem_q[j-1];
      assign lo_in  = dv_lo_q[j-1];
      assign q_in   = dv_q_q[j-1];
      assign rho_in = dv_rho_q[j-1];
      assign neg_in = dv_neg_q[j-1];
      assign ovf_in = dv_ovf_q[j-1];
      assign brg_in = dv_brg_q[j-1];
    end

    // Shift in the next dividend bit
    assign r2 = {rem_in, lo_in[31]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[j] <= 1'b0;
      else if (adv) dv_v_q[j] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_lo_q[j]  <= {lo_in[30:0], 1'b0};
        dv_rho_q[j] <= rho_in;
        dv_neg_q[j] <= neg_in;
        dv_ovf_q[j] <= ovf_in;
        dv_brg_q[j] <= brg_in;
        if (r2 >= {1'b0, rho_in}) begin
          dv_rem_q[j] <= 32'(r2 - {1'b0, rho_in});
          dv_q_q[j]   <= q_in | (32'd1 << B);
        end else begin
          dv_rem_q[j] <= r2[31:0];
          dv_q_q[j]   <= q_in;
        end
      end
    end
  end

  // Output register with range rate saturation
  localparam int L = DIV_STAGES - 1;
  logic [31:0]        out_rho_q;
  logic signed [BRG_W-1:0] out_brg_q;
  logic [31:0]        out_rr_q;
  logic [31:0]        qf;

  assign qf = dv_q_q[L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= dv_v_q[L];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rho_q <= dv_rho_q[L];
      out_brg_q <= dv_brg_q[L];
      if (dv_neg_q[L]) begin
        if (dv_ovf_q[L] || qf > 32'h8000_0000) out_rr_q <= 32'h8000_0000;
        else out_rr_q <= 32'd0 - qf;
      end else begin
        if (dv_ovf_q[L] || qf > 32'h7FFF_FFFF) out_rr_q <= 32'h7FFF_FFFF;
        else out_rr_q <= qf;
      end
    end
  end

  assign out_valid_o      = out_v_q;
  assign range_out_o      = out_rho_q;
  assign bearing_out_o    = out_brg_q;
  assign range_rate_out_o = $signed(out_rr_q);

  `C2P_ASSERT(a_range_nonzero, clk_i, rst_ni, out_v_q |-> (out_rho_q != 32'd0))
  `C2P_ASSERT(a_bearing_bound, clk_i, rst_ni, out_v_q |-> ((out_brg_q <= BRG_W'(BRG_LIM)) && (out_brg_q >= -BRG_W'(BRG_LIM))))
  `C2P_ASSERT(a_hold_divider, clk_i, rst_ni, in_stall_o |=> $stable(dv_v_q[L]) && $stable(dp_v_q))
  `C2P_ASSERT_ALWAYS(a_stall_reason, clk_i, in_stall_o |-> (out_v_q && out_stall_i))

endmodule
`default_nettype wire

// ----- tb/c2p_checker.sv -----
// Scoreboard for the polar conversion unit: predicts range, bearing and range rate
`default_nettype none
module c2p_checker
  import c2p_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire logic signed [31:0]   pos_x_i,
  input  wire logic signed [31:0]   pos_y_i,
  input  wire logic signed [31:0]   vel_x_i,
  input  wire logic signed [31:0]   vel_y_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire logic [31:0]          range_out_i,
  input  wire logic signed [BRG_W-1:0] bearing_out_i,
  input  wire logic signed [31:0]   range_rate_out_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic [31:0]             rng;
    logic signed [BRG_W-1:0] brg;
    logic signed [31:0]      rate;
  } polar_t;

  polar_t polar_q[$];

  // Exact floor square root of a 64-bit magnitude
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Arctangent of 2^-i in Q2.30, own table
  function automatic longint atan_tab(input int i);
    longint tab [10];
    tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tab[i];
    return longint'(1) <<< (30 - i);
  endfunction

  // Vectoring CORDIC angle, rounded to the output fraction and clamped to +-pi
  function automatic logic signed [BRG_W-1:0] cordic_bearing(input logic signed [31:0] px,
                                                             input logic signed [31:0] py);
    longint x, y, z, t, dx, dy, q;
    z = 0;
    if (px == 0 && py == 0) return '0;
    x = longint'(px) <<< ANG_BITS;
    y = longint'(py) <<< ANG_BITS;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q30;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(atan_tab(i));
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(atan_tab(i));
      end
    end
    q = (z + (64'sd1 <<< (BRG_SH - 1))) >>> BRG_SH;
    if (q > BRG_LIM) q = BRG_LIM;
    if (q < -BRG_LIM) q = -BRG_LIM;
    return q[BRG_W-1:0];
  endfunction

  function automatic polar_t predict_polar(input logic signed [31:0] px, py, vx, vy);
    polar_t r;
    logic [63:0] sum, rho, mag, q;
    logic signed [127:0] dot;
    logic neg;
    sum = 64'(longint'(px) * px) + 64'(longint'(py) * py);
    rho = floor_sqrt(sum);
    if (rho < 1) rho = 1;
    dot = 128'(longint'(px) * vx) + 128'(longint'(py) * vy);
    neg = dot < 0;
    mag = neg ? 64'(-dot) : 64'(dot);
    q = mag / rho;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      r.rate = 32'(-q);
    end else begin
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      r.rate = q[31:0];
    end
    r.rng = rho[31:0];
    r.brg = cordic_bearing(px, py);
    return r;
  endfunction

  assign pending_o = polar_q.size();

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    polar_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        polar_q.push_back(predict_polar(pos_x_i, pos_y_i, vel_x_i, vel_y_i));
      if (out_valid_i && !out_stall_i) begin
        if (polar_q.size() == 0) begin
          $error("unexpected result transaction");
          errs++;
        end else begin
          want = polar_q.pop_front();
          if (want.rng !== range_out_i) begin
            $error("range_out expected %0d actual %0d", want.rng, range_out_i);
            errs++;
          end
          if (want.brg !== bearing_out_i) begin
            $error("bearing_out expected %0d actual %0d", want.brg, bearing_out_i);
            errs++;
          end
          if (want.rate !== range_rate_out_i) begin
            $error("range_rate_out expected %0d actual %0d", want.rate, range_rate_out_i);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Stimulus and verdict for the polar conversion unit
`default_nettype none
module tb_top
  import c2p_pkg::*;
();

  localparam int N_RANDOM = 1000;
  localparam int LIMIT    = 400000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [31:0] pos_x_i, pos_y_i, vel_x_i, vel_y_i;
  logic [31:0] range_out_o;
  logic signed [BRG_W-1:0] bearing_out_o;
  logic signed [31:0] range_rate_out_o;
  int fail_count, pending, cycles;
  logic calm, hold_off;

  cartesian_to_polar_range_rate_unit dut (.*);

  c2p_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .pos_x_i, .pos_y_i, .vel_x_i, .vel_y_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .range_out_i(range_out_o), .bearing_out_i(bearing_out_o),
    .range_rate_out_i(range_rate_out_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("[cartesian_to_polar_range_rate_unit] ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off, calm stretch
  initial begin
    out_stall_i = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 0;
        wait (!hold_off);
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 16);
      end
    end
  end

  function automatic logic [31:0] edge_val(input int k);
    case (k % 8)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'h1;
      5: return 32'h0001_0000;
      6: return 32'hFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction and hold it until taken
  task automatic send_state(input logic [31:0] px, py, vx, vy);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    pos_x_i <= px; pos_y_i <= py; vel_x_i <= vx; vel_y_i <= vy;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    logic [31:0] a, b;
    in_valid_i = 0; pos_x_i = 0; pos_y_i = 0; vel_x_i = 0; vel_y_i = 0;
    calm = 0; hold_off = 0;
    rst_ni = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: origin, axes, extremes, saturation
    send_state(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_state(32'hFFFF_0000, 0, 32'h0001_0000, 0);
    send_state(32'h8000_0000, 0, 32'h8000_0000, 0);
    send_state(0, 32'h8000_0000, 0, 32'h8000_0000);
    send_state(1, 0, 32'h7FFF_FFFF, 0);
    send_state(1, 1, 32'h8000_0000, 32'h8000_0000);
    send_state(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_state(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_state(32'hFFFF_FFFF, 1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_state(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321);
    for (int k = 0; k < 12; k++)
      send_state(edge_val(k), edge_val(k + 3), edge_val(k + 5), edge_val(k + 6));
    in_valid_i <= 0;

    // Drain fully before random traffic
    wait (pending == 0);
    @(posedge clk_i);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) hold_off = 1;
      if (n == 300) hold_off = 0;
      calm = (n >= 500 && n < 650);
      case ($urandom_range(3))
        0: begin
          a = edge_val($urandom_range(7));
          b = edge_val($urandom_range(7));
        end
        1: begin
          a = $urandom_range(200) - 100;
          b = $urandom_range(200) - 100;
        end
        default: begin
          a = $urandom; b = $urandom;
        end
      endcase
      send_state(a, b, $urandom, $urandom);
    end
    in_valid_i <= 0;
    calm = 0;

    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0)
      $display("[cartesian_to_polar_range_rate_unit] OK");
    else
      $display("[cartesian_to_polar_range_rate_unit] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
